[rtl/kci_pkg.sv]
// Shared types and constants of the keyframe curve interpolator.
package kci_pkg;

    localparam int TIME_W    = 24;
    localparam int VAL_W     = 32;
    localparam int SLOT_W    = 6;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int KC_W      = 7;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 4;
    localparam int EXT_W     = TIME_W + 1;
    localparam int MAG_W     = VAL_W + 1;
    localparam int PROD_W    = MAG_W + EXT_W;
    localparam int DIVC_W    = $clog2(MAG_W);

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADV   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FEW   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] max_time;
        logic [KC_W-1:0]   key_count;
        logic              loop_enable;
        logic              reverse_mode;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic hold;
    } lane_ctl_t;

    typedef struct packed {
        logic              use_lanes;
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] ntime;
        logic [STAT_W-1:0] stat;
    } res_meta_t;

    typedef struct packed {
        logic all_done;
        logic free;
    } merge_stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_RD_T0, S_RD_TL, S_PREP, S_START, S_FWD, S_REV,
        S_FETCH, S_FETCH_A, S_FETCH_B, S_CALC, S_SPAN, S_LAUNCH, S_WAIT, S_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        L_IDLE, L_MUL, L_DIV, L_FIX
    } lane_state_t;

endpackage

[rtl/keyframe_curve_interpolator_top.sv]
// Top level of the keyframe curve interpolator: config registers, tables, lanes, merge.
//
// Piecewise linear interpolation of four Q16.16 components over a table of up to
// MAX_KEYS time-sorted keys. One word is taken at a time. A query or an advance
// first scans the time table, read one key per cycle, unless it lands on the wrap
// segment without a scan; each of the four lanes then runs a 33-step bit-serial
// divide after one multiply. An advance that clamps at an end skips the divide. A
// finished result waits in the output register while the next word is accepted.
// Configuration writes are always ready.
module keyframe_curve_interpolator_top #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kci_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kci_pkg::TIME_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [kci_pkg::KIND_W-1:0]           kind,
    input  logic [kci_pkg::SLOT_W-1:0]           key_slot,
    input  logic [kci_pkg::TIME_W-1:0]           time_value,
    input  logic [kci_pkg::TIME_W-1:0]           step_dt,
    input  logic signed [kci_pkg::VAL_W-1:0]     value_x,
    input  logic signed [kci_pkg::VAL_W-1:0]     value_y,
    input  logic signed [kci_pkg::VAL_W-1:0]     value_z,
    input  logic signed [kci_pkg::VAL_W-1:0]     value_w,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [kci_pkg::VAL_W-1:0]     out_x,
    output logic signed [kci_pkg::VAL_W-1:0]     out_y,
    output logic signed [kci_pkg::VAL_W-1:0]     out_z,
    output logic signed [kci_pkg::VAL_W-1:0]     out_w,
    output logic [kci_pkg::SLOT_W-1:0]           new_index,
    output logic [kci_pkg::TIME_W-1:0]           new_time,
    output logic [kci_pkg::STAT_W-1:0]           status
);
    import kci_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);

    logic [TIME_W-1:0] max_time_reg, max_time_next;
    logic [KC_W-1:0]   key_count_reg, key_count_next;
    logic              loop_reg, loop_next;
    logic              reverse_reg, reverse_next;
    cfg_t              cfg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [TIME_W-1:0]      t_wdata;
    logic [TIME_W-1:0]      t_rdata;
    logic [LANES*VAL_W-1:0] v_wdata;
    logic [LANES*VAL_W-1:0] v_rdata;
    lane_ctl_t              lane_ctl;
    logic [EXT_W-1:0]       lane_num;
    logic [EXT_W-1:0]       lane_span;
    logic [LANES*VAL_W-1:0] lane_a;
    logic [LANES*VAL_W-1:0] lane_b;
    logic [LANES-1:0]       lane_done;
    logic [LANES*VAL_W-1:0] lane_res;
    merge_stat_t            mstat;
    logic                   push;
    res_meta_t              meta;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_time_reg  <= '0;
            key_count_reg <= '0;
            loop_reg      <= 1'b1;
            reverse_reg   <= 1'b0;
        end
        else
        begin
            max_time_reg  <= max_time_next;
            key_count_reg <= key_count_next;
            loop_reg      <= loop_next;
            reverse_reg   <= reverse_next;
        end
    end

    always_comb
    begin
        max_time_next  = max_time_reg;
        key_count_next = key_count_reg;
        loop_next      = loop_reg;
        reverse_next   = reverse_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_TIME:  max_time_next  = cfg_data;
                CFG_KEY_COUNT: key_count_next = cfg_data[KC_W-1:0];
                CFG_LOOP:      loop_next      = cfg_data[0];
                CFG_REVERSE:   reverse_next   = cfg_data[0];
                default:       max_time_next  = max_time_reg;
            endcase
        end
    end

    assign cfg.max_time     = max_time_reg;
    assign cfg.key_count    = key_count_reg;
    assign cfg.loop_enable  = loop_reg;
    assign cfg.reverse_mode = reverse_reg;

    kci_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (t_wdata),
        .raddr (ram_raddr),
        .rdata (t_rdata)
    );

    kci_ram #(
        .WIDTH (LANES * VAL_W),
        .DEPTH (MAX_KEYS)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (v_wdata),
        .raddr (ram_raddr),
        .rdata (v_rdata)
    );

    kci_seq #(
        .MAX_KEYS (MAX_KEYS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key_slot   (key_slot),
        .time_value (time_value),
        .step_dt    (step_dt),
        .values     ({value_w, value_z, value_y, value_x}),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .t_wdata    (t_wdata),
        .v_wdata    (v_wdata),
        .ram_raddr  (ram_raddr),
        .t_rdata    (t_rdata),
        .v_rdata    (v_rdata),
        .lane_ctl   (lane_ctl),
        .lane_num   (lane_num),
        .lane_span  (lane_span),
        .lane_a     (lane_a),
        .lane_b     (lane_b),
        .mstat      (mstat),
        .push       (push),
        .meta       (meta)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic signed [VAL_W-1:0] res;

        kci_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .a      ($signed(lane_a[g*VAL_W +: VAL_W])),
            .b      ($signed(lane_b[g*VAL_W +: VAL_W])),
            .num    (lane_num),
            .span   (lane_span),
            .done   (lane_done[g]),
            .result (res)
        );

        assign lane_res[g*VAL_W +: VAL_W] = res;
    end

    kci_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .meta      (meta),
        .lane_done (lane_done),
        .lane_res  (lane_res),
        .mstat     (mstat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .new_index (new_index),
        .new_time  (new_time),
        .status    (status)
    );

endmodule

[rtl/kci_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/kci_lane.sv]
// One interpolation lane: multiply by the segment fraction, then a bit-serial divide.
module kci_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kci_pkg::lane_ctl_t                  ctl,
    input  logic signed [kci_pkg::VAL_W-1:0]    a,
    input  logic signed [kci_pkg::VAL_W-1:0]    b,
    input  logic [kci_pkg::EXT_W-1:0]           num,
    input  logic [kci_pkg::EXT_W-1:0]           span,
    output logic                                done,
    output logic signed [kci_pkg::VAL_W-1:0]    result
);
    import kci_pkg::*;

    lane_state_t       state_reg, state_next;
    logic              done_reg, done_next;
    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]  a_reg, a_next;
    logic              neg_reg, neg_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [EXT_W-1:0]  num_reg, num_next;
    logic [EXT_W-1:0]  span_reg, span_next;
    logic [EXT_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  dq_reg, dq_next;
    logic [VAL_W-1:0]  result_reg, result_next;

    logic [MAG_W-1:0]  diff;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [EXT_W:0]    rem2;
    logic [EXT_W:0]    rem_sub;
    logic              ge;
    logic [MAG_W:0]    q_adj;

    assign diff    = {b[VAL_W-1], b} - {a[VAL_W-1], a};
    assign mag     = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    assign prod    = PROD_W'(mag_reg) * PROD_W'(num_reg);
    assign rem2    = {rem_reg, dq_reg[MAG_W-1]};
    assign rem_sub = rem2 - {1'b0, span_reg};
    assign ge      = rem2 >= {1'b0, span_reg};
    assign q_adj   = {1'b0, dq_reg} + (MAG_W + 1)'(neg_reg && (rem_reg != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        num_reg    <= num_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = done_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        num_next    = num_reg;
        span_next   = span_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        result_next = result_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (ctl.start)
                begin
                    a_next    = a;
                    neg_next  = diff[MAG_W-1];
                    mag_next  = mag;
                    num_next  = num;
                    span_next = span;
                    if (ctl.hold)
                    begin
                        result_next = a;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = L_MUL;
                    end
                end
            end
            L_MUL:
            begin
                rem_next   = prod[PROD_W-1:MAG_W];
                dq_next    = prod[MAG_W-1:0];
                cnt_next   = DIVC_W'(MAG_W - 1);
                state_next = L_DIV;
            end
            L_DIV:
            begin
                rem_next = ge ? rem_sub[EXT_W-1:0] : rem2[EXT_W-1:0];
                dq_next  = {dq_reg[MAG_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = L_FIX;
                end
            end
            L_FIX:
            begin
                result_next = neg_reg ? (a_reg - q_adj[VAL_W-1:0])
                                      : (a_reg + q_adj[VAL_W-1:0]);
                done_next   = 1'b1;
                state_next  = L_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = $signed(result_reg);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> (state_reg == L_IDLE))
        else $error("lane started while busy");

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

endmodule

[rtl/kci_merge.sv]
// Merging stage: gathers lane results and status into the output register.
module kci_merge (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    input  kci_pkg::res_meta_t                         meta,
    input  logic [kci_pkg::LANES-1:0]                  lane_done,
    input  logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]   lane_res,
    output kci_pkg::merge_stat_t                       mstat,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [kci_pkg::VAL_W-1:0]           out_x,
    output logic signed [kci_pkg::VAL_W-1:0]           out_y,
    output logic signed [kci_pkg::VAL_W-1:0]           out_z,
    output logic signed [kci_pkg::VAL_W-1:0]           out_w,
    output logic [kci_pkg::SLOT_W-1:0]                 new_index,
    output logic [kci_pkg::TIME_W-1:0]                 new_time,
    output logic [kci_pkg::STAT_W-1:0]                 status
);
    import kci_pkg::*;

    logic                        out_valid_reg, out_valid_next;
    logic [LANES*VAL_W-1:0]      vals_reg, vals_next;
    logic [SLOT_W-1:0]           idx_reg, idx_next;
    logic [TIME_W-1:0]           time_reg, time_next;
    logic [STAT_W-1:0]           stat_reg, stat_next;

    assign mstat.all_done = &lane_done;
    assign mstat.free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vals_reg <= vals_next;
        idx_reg  <= idx_next;
        time_reg <= time_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        vals_next      = vals_reg;
        idx_next       = idx_reg;
        time_next      = time_reg;
        stat_next      = stat_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            vals_next      = meta.use_lanes ? lane_res : '0;
            idx_next       = meta.idx;
            time_next      = meta.ntime;
            stat_next      = meta.stat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = $signed(vals_reg[0*VAL_W +: VAL_W]);
    assign out_y     = $signed(vals_reg[1*VAL_W +: VAL_W]);
    assign out_z     = $signed(vals_reg[2*VAL_W +: VAL_W]);
    assign out_w     = $signed(vals_reg[3*VAL_W +: VAL_W]);
    assign new_index = idx_reg;
    assign new_time  = time_reg;
    assign status    = stat_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> mstat.free)
        else $error("word pushed over an unsent result");

    a_push_lanes_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && meta.use_lanes) |-> mstat.all_done)
        else $error("lane results taken before all lanes finished");

endmodule

[rtl/kci_seq.sv]
// Sequencer: decode, key search over the time table, segment fetch and lane launch.
module kci_seq #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  kci_pkg::cfg_t                               cfg,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [kci_pkg::KIND_W-1:0]                  kind,
    input  logic [kci_pkg::SLOT_W-1:0]                  key_slot,
    input  logic [kci_pkg::TIME_W-1:0]                  time_value,
    input  logic [kci_pkg::TIME_W-1:0]                  step_dt,
    input  logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]    values,
    output logic                                        ram_we,
    output logic [$clog2(MAX_KEYS)-1:0]                 ram_waddr,
    output logic [kci_pkg::TIME_W-1:0]                  t_wdata,
    output logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]    v_wdata,
    output logic [$clog2(MAX_KEYS)-1:0]                 ram_raddr,
    input  logic [kci_pkg::TIME_W-1:0]                  t_rdata,
    input  logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]    v_rdata,
    output kci_pkg::lane_ctl_t                          lane_ctl,
    output logic [kci_pkg::EXT_W-1:0]                   lane_num,
    output logic [kci_pkg::EXT_W-1:0]                   lane_span,
    output logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]    lane_a,
    output logic [kci_pkg::LANES*kci_pkg::VAL_W-1:0]    lane_b,
    input  kci_pkg::merge_stat_t                        mstat,
    output logic                                        push,
    output kci_pkg::res_meta_t                          meta
);
    import kci_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    seq_state_t             state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [TIME_W-1:0]      tv_reg, tv_next;
    logic [TIME_W-1:0]      dt_reg, dt_next;
    logic [LANES*VAL_W-1:0] val_reg, val_next;
    logic [TIME_W-1:0]      t0_reg, t0_next;
    logic [TIME_W-1:0]      tl_reg, tl_next;
    logic [TIME_W-1:0]      dtc_reg, dtc_next;
    logic [TIME_W-1:0]      ct_reg, ct_next;
    logic [CNT_W-1:0]       c_reg, c_next;
    logic [CNT_W-1:0]       nx_reg, nx_next;
    logic [IDX_W-1:0]       seg_a_reg, seg_a_next;
    logic [IDX_W-1:0]       seg_b_reg, seg_b_next;
    logic                   wrap_reg, wrap_next;
    logic                   hold_reg, hold_next;
    logic [TIME_W-1:0]      at_reg, at_next;
    logic [TIME_W-1:0]      btr_reg, btr_next;
    logic [LANES*VAL_W-1:0] va_reg, va_next;
    logic [LANES*VAL_W-1:0] vb_reg, vb_next;
    logic [EXT_W-1:0]       bt_reg, bt_next;
    logic [EXT_W-1:0]       tt_reg, tt_next;
    logic [EXT_W-1:0]       span_reg, span_next;
    logic [EXT_W-1:0]       num_reg, num_next;
    logic                   use_lanes_reg, use_lanes_next;
    logic [SLOT_W-1:0]      ridx_reg, ridx_next;
    logic [TIME_W-1:0]      rtime_reg, rtime_next;
    logic [STAT_W-1:0]      rstat_reg, rstat_next;

    logic [CNT_W-1:0]       n_keys;
    logic [CNT_W-1:0]       n_last;
    logic                   slot_ok;
    logic                   slot_big;
    logic [EXT_W-1:0]       fwd_sum;
    logic [TIME_W-1:0]      fwd_wrapped;
    logic [TIME_W-1:0]      rev_wrapped;
    logic [EXT_W-1:0]       t0_plus;
    logic [EXT_W-1:0]       btr_plus;
    logic [EXT_W-1:0]       ct_plus;

    assign n_keys      = (int'(cfg.key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS)
                                                          : CNT_W'(cfg.key_count);
    assign n_last      = n_keys - 1'b1;
    assign slot_ok     = int'(slot_reg) < MAX_KEYS;
    assign slot_big    = int'(slot_reg) >= int'(n_keys);
    assign fwd_sum     = {1'b0, tv_reg} + {1'b0, dtc_reg};
    assign fwd_wrapped = TIME_W'(fwd_sum - {1'b0, cfg.max_time});
    assign rev_wrapped = TIME_W'({1'b0, tv_reg} + {1'b0, cfg.max_time} - {1'b0, dtc_reg});
    assign t0_plus     = {1'b0, t0_reg} + {1'b0, cfg.max_time};
    assign btr_plus    = {1'b0, btr_reg} + {1'b0, cfg.max_time};
    assign ct_plus     = {1'b0, ct_reg} + {1'b0, cfg.max_time};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        tv_reg        <= tv_next;
        dt_reg        <= dt_next;
        val_reg       <= val_next;
        t0_reg        <= t0_next;
        tl_reg        <= tl_next;
        dtc_reg       <= dtc_next;
        ct_reg        <= ct_next;
        c_reg         <= c_next;
        nx_reg        <= nx_next;
        seg_a_reg     <= seg_a_next;
        seg_b_reg     <= seg_b_next;
        wrap_reg      <= wrap_next;
        hold_reg      <= hold_next;
        at_reg        <= at_next;
        btr_reg       <= btr_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        bt_reg        <= bt_next;
        tt_reg        <= tt_next;
        span_reg      <= span_next;
        num_reg       <= num_next;
        use_lanes_reg <= use_lanes_next;
        ridx_reg      <= ridx_next;
        rtime_reg     <= rtime_next;
        rstat_reg     <= rstat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        tv_next        = tv_reg;
        dt_next        = dt_reg;
        val_next       = val_reg;
        t0_next        = t0_reg;
        tl_next        = tl_reg;
        dtc_next       = dtc_reg;
        ct_next        = ct_reg;
        c_next         = c_reg;
        nx_next        = nx_reg;
        seg_a_next     = seg_a_reg;
        seg_b_next     = seg_b_reg;
        wrap_next      = wrap_reg;
        hold_next      = hold_reg;
        at_next        = at_reg;
        btr_next       = btr_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        bt_next        = bt_reg;
        tt_next        = tt_reg;
        span_next      = span_reg;
        num_next       = num_reg;
        use_lanes_next = use_lanes_reg;
        ridx_next      = ridx_reg;
        rtime_next     = rtime_reg;
        rstat_next     = rstat_reg;
        in_stall       = 1'b1;
        ram_we         = 1'b0;
        ram_raddr      = '0;
        lane_ctl       = '0;
        push           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    kind_next  = kind;
                    slot_next  = key_slot;
                    tv_next    = time_value;
                    dt_next    = step_dt;
                    val_next   = values;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                use_lanes_next = 1'b0;
                ridx_next      = slot_reg;
                rtime_next     = tv_reg;
                rstat_next     = STAT_OK;
                state_next     = S_FINISH;
                priority if (kind_reg == KIND_LOAD)
                begin
                    ram_we     = slot_ok;
                    rstat_next = slot_ok ? STAT_OK : STAT_RANGE;
                end
                else if (kind_reg != KIND_ADV && kind_reg != KIND_QUERY)
                begin
                    ridx_next  = '0;
                    rtime_next = '0;
                    rstat_next = STAT_RANGE;
                end
                else if (n_keys < CNT_W'(2))
                begin
                    rstat_next = STAT_FEW;
                end
                else if (tv_reg > cfg.max_time || (kind_reg == KIND_ADV && slot_big))
                begin
                    rstat_next = STAT_RANGE;
                end
                else
                begin
                    state_next = S_RD_T0;
                end
            end
            S_RD_T0:
            begin
                t0_next    = t_rdata;
                ram_raddr  = IDX_W'(n_last);
                dtc_next   = (dt_reg > cfg.max_time) ? cfg.max_time : dt_reg;
                state_next = S_RD_TL;
            end
            S_RD_TL:
            begin
                tl_next    = t_rdata;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                hold_next  = 1'b0;
                wrap_next  = 1'b0;
                state_next = S_START;
                priority if (kind_reg == KIND_QUERY)
                begin
                    ct_next = tv_reg;
                    c_next  = '0;
                end
                else if (!cfg.reverse_mode)
                begin
                    if (fwd_sum > {1'b0, cfg.max_time})
                    begin
                        if (cfg.loop_enable)
                        begin
                            ct_next = fwd_wrapped;
                            c_next  = '0;
                        end
                        else
                        begin
                            ct_next   = cfg.max_time;
                            c_next    = n_last;
                            hold_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ct_next = fwd_sum[TIME_W-1:0];
                        c_next  = CNT_W'(slot_reg);
                    end
                end
                else
                begin
                    if (dtc_reg > tv_reg)
                    begin
                        if (cfg.loop_enable)
                        begin
                            ct_next = rev_wrapped;
                            c_next  = n_last;
                        end
                        else
                        begin
                            ct_next   = '0;
                            c_next    = '0;
                            hold_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ct_next = tv_reg - dtc_reg;
                        c_next  = CNT_W'(slot_reg);
                    end
                end
            end
            S_START:
            begin
                seg_a_next = IDX_W'(n_last);
                seg_b_next = '0;
                state_next = S_FETCH;
                priority if (hold_reg)
                begin
                    seg_a_next = IDX_W'(c_reg);
                end
                else if (kind_reg == KIND_QUERY)
                begin
                    if (ct_reg <= t0_reg || ct_reg >= tl_reg)
                    begin
                        wrap_next = 1'b1;
                        c_next    = n_last;
                    end
                    else
                    begin
                        nx_next    = CNT_W'(1);
                        ram_raddr  = IDX_W'(1);
                        state_next = S_FWD;
                    end
                end
                else if (!cfg.reverse_mode)
                begin
                    if (c_reg == '0 && ct_reg < t0_reg)
                    begin
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        nx_next    = c_reg + 1'b1;
                        ram_raddr  = IDX_W'(c_reg + 1'b1);
                        state_next = S_FWD;
                    end
                end
                else
                begin
                    if ((c_reg == n_last && ct_reg > tl_reg) || c_reg == '0)
                    begin
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        ram_raddr  = IDX_W'(c_reg - 1'b1);
                        state_next = S_REV;
                    end
                end
            end
            S_FWD:
            begin
                if (nx_reg < n_keys && t_rdata < ct_reg)
                begin
                    nx_next   = nx_reg + 1'b1;
                    c_next    = c_reg + 1'b1;
                    ram_raddr = IDX_W'(nx_reg + 1'b1);
                end
                else if (nx_reg >= n_keys)
                begin
                    wrap_next  = 1'b1;
                    seg_a_next = IDX_W'(n_last);
                    seg_b_next = '0;
                    state_next = S_FETCH;
                end
                else
                begin
                    seg_a_next = IDX_W'(c_reg);
                    seg_b_next = IDX_W'(nx_reg);
                    state_next = S_FETCH;
                end
            end
            S_REV:
            begin
                if (t_rdata > ct_reg)
                begin
                    c_next = c_reg - 1'b1;
                    if (c_reg == CNT_W'(1))
                    begin
                        wrap_next  = 1'b1;
                        seg_a_next = IDX_W'(n_last);
                        seg_b_next = '0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        ram_raddr = IDX_W'(c_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    seg_a_next = IDX_W'(c_reg - 1'b1);
                    seg_b_next = IDX_W'(c_reg);
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ram_raddr  = seg_a_reg;
                state_next = S_FETCH_A;
            end
            S_FETCH_A:
            begin
                at_next    = t_rdata;
                va_next    = v_rdata;
                ram_raddr  = seg_b_reg;
                state_next = hold_reg ? S_LAUNCH : S_FETCH_B;
            end
            S_FETCH_B:
            begin
                btr_next   = t_rdata;
                vb_next    = v_rdata;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (wrap_reg)
                begin
                    bt_next = t0_plus;
                end
                else
                begin
                    bt_next = (at_reg > btr_reg) ? btr_plus : {1'b0, btr_reg};
                end
                tt_next    = (ct_reg < at_reg) ? ct_plus : {1'b0, ct_reg};
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                hold_next  = bt_reg <= {1'b0, at_reg};
                span_next  = bt_reg - {1'b0, at_reg};
                num_next   = (tt_reg > {1'b0, at_reg}) ? (tt_reg - {1'b0, at_reg}) : '0;
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                lane_ctl.start = 1'b1;
                lane_ctl.hold  = hold_reg;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (mstat.all_done)
                begin
                    use_lanes_next = 1'b1;
                    ridx_next      = SLOT_W'(c_reg);
                    rtime_next     = ct_reg;
                    rstat_next     = STAT_OK;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (mstat.free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign ram_waddr      = IDX_W'(slot_reg);
    assign t_wdata        = tv_reg;
    assign v_wdata        = val_reg;
    assign lane_num       = (num_reg > span_reg) ? span_reg : num_reg;
    assign lane_span      = span_reg;
    assign lane_a         = va_reg;
    assign lane_b         = vb_reg;
    assign meta.use_lanes = use_lanes_reg;
    assign meta.idx       = ridx_reg;
    assign meta.ntime     = rtime_reg;
    assign meta.stat      = rstat_reg;

    a_we_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (kind_reg == KIND_LOAD && state_reg == S_DECODE))
        else $error("table written outside a key load");

    a_fwd_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD) |-> (nx_reg == c_reg + 1'b1))
        else $error("forward scan lost the key pair");

    a_rev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV) |-> (c_reg != '0))
        else $error("reverse scan below first key");

endmodule
